// ===== design/tmq_pkg.sv =====
// Shared types and constants for the timed event queue.
package tmq_pkg;

   localparam int ACTION_W = 2;
   localparam int TIME_W   = 32;
   localparam int EVID_W   = 16;
   localparam int STATUS_W = 3;
   localparam int RCNT_W   = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD     = 2'd0,
      ACT_REMOVE  = 2'd1,
      ACT_ADVANCE = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_FIRED    = 3'd0,
      ST_ADDED    = 3'd1,
      ST_PAST     = 3'd2,
      ST_FULL     = 3'd3,
      ST_REMOVED  = 3'd4,
      ST_ADV_DONE = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REPLY,
      S_ADD_SCAN,
      S_REM_SCAN,
      S_ADV_SCAN
   } state_type;

   // One result headed for the output register.
   typedef struct packed {
      logic              valid;
      status_type        status;
      logic [EVID_W-1:0] fired_id;
      logic [RCNT_W-1:0] removed_count;
      logic              last;
   } rsp_load_type;

endpackage

// ===== design/tmq_chan_if.sv =====
// Request and response channel interfaces of the timed event queue.
interface tmq_req_if import tmq_pkg::*;;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [TIME_W-1:0]   time_value;
   logic [EVID_W-1:0]   event_id;

   modport source (output valid, output action, output time_value, output event_id,
                   input ready);
   modport sink (input valid, input action, input time_value, input event_id,
                 output ready);
endinterface

interface tmq_rsp_if import tmq_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [EVID_W-1:0]   fired_id;
   logic [RCNT_W-1:0]   removed_count;
   logic                last;

   modport source (output valid, output status, output fired_id, output removed_count,
                   output last, input ready);
   modport sink (input valid, input status, input fired_id, input removed_count,
                 input last, output ready);
endinterface

// ===== design/tmq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tmq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tmq_out.sv =====
// Output register of the response channel.
module tmq_out import tmq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  rsp_load_type     load,
   output logic             out_stall,
   tmq_rsp_if.source        rsp_if
);

   logic         valid_ff, valid_in;
   rsp_load_type data_ff, data_in;

   // hold while the sink refuses; the sequencer only loads when not stalled
   assign out_stall = valid_ff && !rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load.valid) begin
         valid_in = 1'b1;
         data_in  = load;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.status        = STATUS_W'(data_ff.status);
   assign rsp_if.fired_id      = data_ff.fired_id;
   assign rsp_if.removed_count = data_ff.removed_count;
   assign rsp_if.last          = data_ff.last;

endmodule

// ===== design/timed_event_queue.sv =====
// Top level of the timed event queue: sequencer, entry RAM and response register.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+-------------------------------------------
//   req_if   | in  | valid / ready  | action, time_value, event_id
//   rsp_if   | out | valid / ready  | status, fired_id, removed_count, last
//
// A request is accepted in S_IDLE and then scans the queued entries with one RAM
// read and one RAM write per cycle while the output does not stall, shared
// by the insertion scan (descending) and the compaction scan (ascending).
// Rejects reply from S_REPLY; unused actions return to S_IDLE with no reply.
// Reset clears the entry count and current time; the RAM needs no clearing.
// Scan and reply states freeze while the response register is full and not taken.
module timed_event_queue import tmq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 16
) (
   input  logic      clock,
   input  logic      reset,
   tmq_req_if.sink   req_if,
   tmq_rsp_if.source rsp_if
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int ENT_W = TIME_W + ID_BITS;

   // control state
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                pend_ff, pend_in;
   // payload registers of the request at work
   logic [TIME_W-1:0]   key_ff, key_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   logic [IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0]    wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   status_type          reply_ff, reply_in;

   // RAM port
   logic                ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]    ram_wr_addr, ram_rd_addr;
   logic [ENT_W-1:0]    ram_wr_data, ram_rd_data;

   // shared compare unit and helpers
   logic [TIME_W-1:0]   q_time;
   logic [ID_BITS-1:0]  q_id;
   logic                q_le, q_eq, hit;
   logic                req_fire, out_stall, asc_end, add_place, full;
   logic [TIME_W:0]     adv_sum;
   logic [TIME_W-1:0]   adv_time;
   logic [CNT_W-1:0]    rd_dec;
   logic [31:0]         id_wide, fired_wide, rem_wide;
   rsp_load_type        load;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;

   // saturating advance of the current time
   assign adv_sum  = {1'b0, now_ff} + {1'b0, req_if.time_value};
   assign adv_time = adv_sum[TIME_W] ? '1 : adv_sum[TIME_W-1:0];

   // keep the low ID_BITS of the id; show the low 16 bits on the way out
   assign id_wide    = 32'(req_if.event_id);
   assign q_time     = ram_rd_data[ENT_W-1:ID_BITS];
   assign q_id       = ram_rd_data[ID_BITS-1:0];
   assign fired_wide = 32'(q_id);
   assign rem_wide   = 32'(rem_ff);

   assign q_le = (q_time <= key_ff);
   assign q_eq = (q_time == key_ff);
   assign hit  = (state_ff == S_REM_SCAN) ? q_eq : q_le;

   assign full      = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign rd_dec    = rd_idx_ff - 1'b1;
   // ascending scan is over once nothing is in flight and every entry was read
   assign asc_end   = !pend_ff && (rd_idx_ff >= cnt_ff);
   // insertion point found: an earlier-or-equal entry, or the queue head
   assign add_place = pend_ff ? q_le : (rd_idx_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_if.action)
                  ACT_ADD: begin
                     if (req_if.time_value < now_ff || full) begin
                        state_in = S_REPLY;
                     end else begin
                        state_in = S_ADD_SCAN;
                     end
                  end
                  ACT_REMOVE:  state_in = S_REM_SCAN;
                  ACT_ADVANCE: state_in = S_ADV_SCAN;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_REPLY: begin
            if (!out_stall) state_in = S_IDLE;
         end
         S_ADD_SCAN: begin
            if (!out_stall && add_place) state_in = S_IDLE;
         end
         S_REM_SCAN, S_ADV_SCAN: begin
            if (!out_stall && asc_end) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath, RAM control and results
   always_comb begin
      cnt_in      = cnt_ff;
      now_in      = now_ff;
      rd_idx_in   = rd_idx_ff;
      pend_in     = pend_ff;
      key_in      = key_ff;
      id_in       = id_ff;
      pend_idx_in = pend_idx_ff;
      wr_idx_in   = wr_idx_ff;
      rem_in      = rem_ff;
      reply_in    = reply_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      load        = '0;
      load.status = ST_FIRED;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               key_in    = req_if.time_value;
               id_in     = id_wide[ID_BITS-1:0];
               pend_in   = 1'b0;
               wr_idx_in = '0;
               rem_in    = '0;
               rd_idx_in = '0;
               reply_in  = (req_if.time_value < now_ff) ? ST_PAST : ST_FULL;
               unique case (req_if.action)
                  ACT_ADD: rd_idx_in = cnt_ff;   // scan down from the tail
                  ACT_ADVANCE: begin
                     key_in = adv_time;
                     now_in = adv_time;
                  end
                  default: ;
               endcase
            end
         end

         S_REPLY: begin
            if (!out_stall) begin
               load.valid  = 1'b1;
               load.status = reply_ff;
               load.last   = 1'b1;
            end
         end

         S_ADD_SCAN: begin
            if (!out_stall) begin
               if (add_place) begin
                  // drop the new event in and close
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = pend_ff ? pend_idx_ff + 1'b1 : '0;
                  ram_wr_data = {key_ff, id_ff};
                  cnt_in      = cnt_ff + 1'b1;
                  pend_in     = 1'b0;
                  load.valid  = 1'b1;
                  load.status = ST_ADDED;
                  load.last   = 1'b1;
               end else begin
                  if (pend_ff) begin
                     // later entry: shift it up by one
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = pend_idx_ff + 1'b1;
                     ram_wr_data = ram_rd_data;
                  end
                  if (rd_idx_ff == '0) begin
                     // head moved up: clear pend so that the new event is placed at slot zero
                     pend_in = 1'b0;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = rd_dec[IDX_W-1:0];
                     pend_in     = 1'b1;
                     pend_idx_in = rd_dec[IDX_W-1:0];
                     rd_idx_in   = rd_dec;
                  end
               end
            end
         end

         S_REM_SCAN, S_ADV_SCAN: begin
            if (!out_stall) begin
               if (pend_ff) begin
                  if (hit) begin
                     if (state_ff == S_REM_SCAN) begin
                        rem_in = rem_ff + 1'b1;
                     end else begin
                        load.valid    = 1'b1;
                        load.status   = ST_FIRED;
                        load.fired_id = fired_wide[EVID_W-1:0];
                     end
                  end else begin
                     // keep the entry: compact it down
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = wr_idx_ff[IDX_W-1:0];
                     ram_wr_data = ram_rd_data;
                     wr_idx_in   = wr_idx_ff + 1'b1;
                  end
               end
               if (rd_idx_ff < cnt_ff) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = rd_idx_ff[IDX_W-1:0];
                  pend_in     = 1'b1;
                  pend_idx_in = rd_idx_ff[IDX_W-1:0];
                  rd_idx_in   = rd_idx_ff + 1'b1;
               end else begin
                  pend_in = 1'b0;
               end
               if (asc_end) begin
                  cnt_in     = wr_idx_ff;
                  load.valid = 1'b1;
                  load.last  = 1'b1;
                  if (state_ff == S_REM_SCAN) begin
                     load.status        = ST_REMOVED;
                     load.removed_count = rem_wide[RCNT_W-1:0];
                  end else begin
                     load.status = ST_ADV_DONE;
                  end
               end
            end
         end

         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         now_ff    <= '0;
         rd_idx_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         now_ff    <= now_in;
         rd_idx_ff <= rd_idx_in;
         pend_ff   <= pend_in;
      end
      key_ff      <= key_in;
      id_ff       <= id_in;
      pend_idx_ff <= pend_idx_in;
      wr_idx_ff   <= wr_idx_in;
      rem_ff      <= rem_in;
      reply_ff    <= reply_in;
   end

   tmq_ram #(
      .WIDTH (ENT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tmq_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .out_stall (out_stall),
      .rsp_if    (rsp_if)
   );

endmodule
